@@ rtl/fpd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package fpd_pkg;
    localparam logic [2:0] PH_PRELIFTOFF  = 3'd0;
    localparam logic [2:0] PH_LIFTOFF     = 3'd1;
    localparam logic [2:0] PH_CUTOFF      = 3'd2;
    localparam logic [2:0] PH_EXP_STARTED = 3'd3;
    localparam logic [2:0] PH_EXP_DONE    = 3'd4;
    localparam logic [2:0] PH_DESCENDING  = 3'd5;
    localparam logic [2:0] PH_LANDED      = 3'd6;

    localparam logic [2:0] REG_LIFTOFF_THR = 3'd0;
    localparam logic [2:0] REG_CUTOFF_THR  = 3'd1;
    localparam logic [2:0] REG_DESCENT_THR = 3'd2;
    localparam logic [2:0] REG_SPIKE_THR   = 3'd3;
    localparam logic [2:0] REG_LAND_LOW    = 3'd4;
    localparam logic [2:0] REG_LAND_HIGH   = 3'd5;
    localparam logic [2:0] REG_LIFTOFF_TO  = 3'd6;
    localparam logic [2:0] REG_COAST_DELAY = 3'd7;

    localparam logic [15:0] RST_LIFTOFF_THR = 16'd1011;
    localparam logic [15:0] RST_CUTOFF_THR  = 16'd256;
    localparam logic [15:0] RST_DESCENT_THR = 16'd1024;
    localparam logic [15:0] RST_SPIKE_THR   = 16'd17920;
    localparam logic [15:0] RST_LAND_LOW    = 16'd1792;
    localparam logic [15:0] RST_LAND_HIGH   = 16'd3072;
    localparam logic [31:0] RST_LIFTOFF_TO  = 32'd150000;
    localparam logic [31:0] RST_COAST_DELAY = 32'd36000;

    localparam logic [31:0] GUARD_MS      = 32'd4000;
    localparam logic [32:0] EXPERIMENT_MS = 33'd110000;

    typedef struct packed {
        logic       load;
        logic       sq_step;
        logic [1:0] sq_sel;
        logic       root_step;
        logic       mem_rd;
        logic       upd;
        logic       div_init;
        logic       decide;
        logic       out_load;
    } fpd_cmd_t;
endpackage
`default_nettype wire

@@ rtl/fpd_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module fpd_datapath import fpd_pkg::*; #(
    parameter int RING_DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire fpd_cmd_t    cmd,
    input  wire logic [31:0] s_time_ms,
    input  wire logic [15:0] s_accel_x,
    input  wire logic [15:0] s_accel_y,
    input  wire logic [15:0] s_accel_z,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata,
    output logic [2:0]       m_phase,
    output logic [2:0]       m_previous_phase
);
    localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SW = 16 + $clog2(RING_DEPTH);
    localparam int LW = $clog2(RING_DEPTH);
    localparam int KW = SW + LW;
    localparam int PW = 2 * SW + 1;
    localparam logic [SW:0] RECIP =
        (SW+1)'(((64'd1 << KW) + 64'(RING_DEPTH - 1)) / 64'(RING_DEPTH));
    localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);

    logic [15:0] liftoff_thr_reg, cutoff_thr_reg, descent_thr_reg, spike_thr_reg;
    logic [15:0] land_low_reg, land_high_reg;
    logic [31:0] liftoff_to_reg, coast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            liftoff_thr_reg <= RST_LIFTOFF_THR;
            cutoff_thr_reg  <= RST_CUTOFF_THR;
            descent_thr_reg <= RST_DESCENT_THR;
            spike_thr_reg   <= RST_SPIKE_THR;
            land_low_reg    <= RST_LAND_LOW;
            land_high_reg   <= RST_LAND_HIGH;
            liftoff_to_reg  <= RST_LIFTOFF_TO;
            coast_reg       <= RST_COAST_DELAY;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_LIFTOFF_THR: liftoff_thr_reg <= cfg_wdata[15:0];
                REG_CUTOFF_THR:  cutoff_thr_reg  <= cfg_wdata[15:0];
                REG_DESCENT_THR: descent_thr_reg <= cfg_wdata[15:0];
                REG_SPIKE_THR:   spike_thr_reg   <= cfg_wdata[15:0];
                REG_LAND_LOW:    land_low_reg    <= cfg_wdata[15:0];
                REG_LAND_HIGH:   land_high_reg   <= cfg_wdata[15:0];
                REG_LIFTOFF_TO:  liftoff_to_reg  <= cfg_wdata;
                REG_COAST_DELAY: coast_reg       <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // magnitude: squares, then one root bit per step
    logic [31:0] time_reg;
    logic [15:0] ax_reg, ay_reg, az_reg;
    logic [31:0] rad_reg;
    logic [17:0] rem_reg;
    logic [15:0] root_reg;
    logic [15:0] sq_op;
    logic [31:0] sq_prod;
    logic [17:0] rem_t, trial;

    always_comb begin
        case (cmd.sq_sel)
            2'd0:    sq_op = ax_reg;
            2'd1:    sq_op = ay_reg;
            default: sq_op = az_reg;
        endcase
        sq_prod = sq_op * sq_op;
        rem_t   = {rem_reg[15:0], rad_reg[31:30]};
        trial   = {root_reg, 2'b01};
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            time_reg <= s_time_ms;
            ax_reg   <= s_accel_x[15] ? 16'(-s_accel_x) : s_accel_x;
            ay_reg   <= s_accel_y[15] ? 16'(-s_accel_y) : s_accel_y;
            az_reg   <= s_accel_z[15] ? 16'(-s_accel_z) : s_accel_z;
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cmd.sq_step) begin
            rad_reg <= rad_reg + sq_prod;
        end else if (cmd.root_step) begin
            rad_reg <= {rad_reg[29:0], 2'b00};
            if (rem_t >= trial) begin
                rem_reg  <= rem_t - trial;
                root_reg <= {root_reg[14:0], 1'b1};
            end else begin
                rem_reg  <= rem_t;
                root_reg <= {root_reg[14:0], 1'b0};
            end
        end
    end

    // rings
    logic [15:0] new_mem [RING_DEPTH];
    logic [15:0] old_mem [RING_DEPTH];
    logic [15:0] new_q, old_q;
    logic [IW-1:0] idx_reg;
    logic ring_full_reg, old_full_reg;
    logic [SW-1:0] new_sum_reg, old_sum_reg;
    logic [15:0] moved, old_out;

    assign moved   = ring_full_reg ? new_q : 16'd0;
    assign old_out = old_full_reg ? old_q : 16'd0;

    always_ff @(posedge aclk) begin
        if (cmd.mem_rd) begin
            new_q <= new_mem[idx_reg];
            old_q <= old_mem[idx_reg];
        end
        if (cmd.upd) begin
            new_mem[idx_reg] <= root_reg;
            if (ring_full_reg) begin
                old_mem[idx_reg] <= moved;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            ring_full_reg <= 1'b0;
            old_full_reg  <= 1'b0;
            new_sum_reg   <= '0;
            old_sum_reg   <= '0;
        end else if (cmd.upd) begin
            new_sum_reg <= new_sum_reg - SW'(moved) + SW'(root_reg);
            if (ring_full_reg) begin
                old_sum_reg <= old_sum_reg - SW'(old_out) + SW'(moved);
            end
            if (idx_reg == LAST_IDX) begin
                idx_reg       <= '0;
                ring_full_reg <= 1'b1;
                if (ring_full_reg) begin
                    old_full_reg <= 1'b1;
                end
            end else begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // averages: both sums times the reciprocal of the depth, exact floor
    logic [PW-1:0] n_prod, o_prod;
    logic [15:0]   nq_reg, oq_reg;

    assign n_prod = PW'(new_sum_reg) * PW'(RECIP);
    assign o_prod = PW'(old_sum_reg) * PW'(RECIP);

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            nq_reg <= n_prod[KW +: 16];
            oq_reg <= o_prod[KW +: 16];
        end
    end

    // phase decision
    logic [15:0] new_avg, old_avg;
    logic [2:0]  phase_reg, prior_reg;
    logic [31:0] launch_reg, cutoff_reg;
    logic        spike_reg, spike_n;
    logic [31:0] since_cut, since_launch;
    logic [32:0] exp_limit;
    logic        c_lift, c_cut, c_exp, c_done, c_desc, c_land;

    always_comb begin
        new_avg      = nq_reg;
        old_avg      = oq_reg;
        since_cut    = time_reg - cutoff_reg;
        since_launch = time_reg - launch_reg;
        exp_limit    = EXPERIMENT_MS + {1'b0, coast_reg};
        spike_n = spike_reg | ((phase_reg >= PH_DESCENDING) && (root_reg >= spike_thr_reg));
        c_lift = (phase_reg == PH_PRELIFTOFF) &&
                 ({1'b0, new_avg} > ({1'b0, old_avg} + {1'b0, liftoff_thr_reg}));
        c_cut  = ((phase_reg <= PH_LIFTOFF) && (new_avg < cutoff_thr_reg)) ||
                 ((phase_reg == PH_LIFTOFF) && (since_launch >= liftoff_to_reg));
        c_exp  = (phase_reg == PH_CUTOFF) && (since_cut >= coast_reg);
        c_done = (phase_reg == PH_EXP_STARTED) && ({1'b0, since_cut} >= exp_limit);
        c_desc = ((phase_reg == PH_EXP_STARTED) || (phase_reg == PH_EXP_DONE)) &&
                 (new_avg > descent_thr_reg);
        c_land = (phase_reg >= PH_DESCENDING) && spike_n &&
                 (new_avg >= land_low_reg) && (new_avg <= land_high_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_PRELIFTOFF;
            prior_reg  <= PH_PRELIFTOFF;
            launch_reg <= '0;
            cutoff_reg <= '0;
            spike_reg  <= 1'b0;
        end else if (cmd.decide && (time_reg > GUARD_MS)) begin
            spike_reg <= spike_n;
            if (c_lift) begin
                launch_reg <= time_reg;
                prior_reg  <= phase_reg;
                phase_reg  <= PH_LIFTOFF;
            end else if (c_cut) begin
                cutoff_reg <= time_reg;
                prior_reg  <= phase_reg;
                phase_reg  <= PH_CUTOFF;
            end else if (c_exp) begin
                prior_reg <= phase_reg;
                phase_reg <= PH_EXP_STARTED;
            end else if (c_done) begin
                prior_reg <= phase_reg;
                phase_reg <= PH_EXP_DONE;
            end else if (c_desc) begin
                prior_reg <= phase_reg;
                phase_reg <= PH_DESCENDING;
            end else if (c_land) begin
                spike_reg <= 1'b0;
                prior_reg <= phase_reg;
                phase_reg <= PH_LANDED;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_phase          <= phase_reg;
            m_previous_phase <= prior_reg;
        end
    end
endmodule
`default_nettype wire

@@ rtl/fpd_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none
module fpd_controller import fpd_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    output fpd_cmd_t  cmd
);
    localparam int CW = 5;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SQ    = 4'd1;
    localparam logic [3:0] ST_ROOT  = 4'd2;
    localparam logic [3:0] ST_RD    = 4'd3;
    localparam logic [3:0] ST_UPD   = 4'd4;
    localparam logic [3:0] ST_DINIT = 4'd5;
    localparam logic [3:0] ST_DEC   = 4'd6;
    localparam logic [3:0] ST_OUT   = 4'd7;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          m_valid_reg, m_valid_next;
    logic          out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.sq_sel   = cnt_reg[1:0];
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                cmd.sq_step = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CW'(2)) begin
                    cnt_next   = '0;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CW'(15)) begin
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                cmd.upd    = 1'b1;
                state_next = ST_DINIT;
            end
            ST_DINIT: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DEC;
            end
            ST_DEC: begin
                cmd.decide = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_SQ)
        else $error("accepted item did not start squaring");
    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_OUT && m_valid_reg && !m_ready |=> state_reg == ST_OUT)
        else $error("result overwritten while stalled");
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.sq_step, cmd.root_step, cmd.mem_rd, cmd.upd,
                  cmd.div_init, cmd.decide, cmd.out_load}))
        else $error("more than one datapath command");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(16))
        else $error("step counter out of range");
endmodule
`default_nettype wire

@@ rtl/flight_phase_detector.sv @@
// Flight phase detector.
// Input channel s_*: one item per accelerometer sample, a millisecond
// timestamp and three signed Q8.8 axes, valid/ready. Result channel m_*:
// one item per input, the current phase and the phase before the last
// transition. Threshold and timing registers are written through cfg_we,
// cfg_addr, cfg_wdata; the user must write them only while the block is
// idle, which the block itself does not enforce; they take effect at once.
// Per item: three squares on one multiplier, a 16-bit square root (one
// result bit a cycle), ring read and update, both averages formed by a
// reciprocal multiply, the decision, then the output load; m_valid and
// s_ready rise together, and no new item is taken before that load.
// The result sits in an output register, so a stalled receiver does not
// stop the next item being accepted and worked; only its own output
// waits, and s_ready stays low until the held result is taken.
// Reset empties the rings and clears the sums, phase state and registers
// to their defaults.
`timescale 1ns / 1ps
`default_nettype none
module flight_phase_detector import fpd_pkg::*; #(
    parameter int RING_DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_time_ms,
    input  wire logic [15:0] s_accel_x,
    input  wire logic [15:0] s_accel_y,
    input  wire logic [15:0] s_accel_z,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_phase,
    output logic [2:0]       m_previous_phase,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata
);
    fpd_cmd_t cmd;

    fpd_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    fpd_datapath #(.RING_DEPTH(RING_DEPTH)) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .s_time_ms        (s_time_ms),
        .s_accel_x        (s_accel_x),
        .s_accel_y        (s_accel_y),
        .s_accel_z        (s_accel_z),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .m_phase          (m_phase),
        .m_previous_phase (m_previous_phase)
    );
endmodule
`default_nettype wire
